// File: rtl/core/one_wire_temperature_reader_assert.svh
// Assertion macros for the single-wire temperature reader.
`ifndef ONE_WIRE_TEMPERATURE_READER_ASSERT_SVH
`define ONE_WIRE_TEMPERATURE_READER_ASSERT_SVH

// Property that must hold at every edge outside reset.
`define OWTR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle requires the consequent in the next one.
`define OWTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/owtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_pkg
// Types, register indexes and constants of the single-wire temperature reader.
// ----------------------------------------------------------------------------
package owtr_pkg;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_PRES_WAIT = 4'd2,
    PH_POST      = 4'd3,
    PH_WR_LOW    = 4'd4,
    PH_WR_HOLD   = 4'd5,
    PH_WR_GAP    = 4'd6,
    PH_CONV      = 4'd7,
    PH_RD_LOW    = 4'd8,
    PH_RD_WAIT   = 4'd9,
    PH_RD_SLOT   = 4'd10
  } phase_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_TMO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_PRES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SLOT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_WAIT  = 3'd6;

  localparam logic [15:0] RST_RESET_LOW  = 16'd480;
  localparam logic [15:0] RST_PRES_TMO   = 16'd5000;
  localparam logic [15:0] RST_POST_PRES  = 16'd100;
  localparam logic [15:0] RST_WRITE_HOLD = 16'd68;
  localparam logic [7:0]  RST_READ_SAMP  = 8'd2;
  localparam logic [15:0] RST_READ_SLOT  = 16'd48;
  localparam logic [19:0] RST_CONV_WAIT  = 20'd0;

  localparam logic [7:0] CMD_SKIP_ROM  = 8'hcc;
  localparam logic [7:0] CMD_CONVERT   = 8'h44;
  localparam logic [7:0] CMD_READ_SCR  = 8'hbe;

  // Byte slots of the sequence: four command bytes, then two read bytes.
  localparam logic [2:0] BYTE_CMDS     = 3'd4;
  localparam logic [2:0] BYTE_CONV_END = 3'd2;
  localparam logic [2:0] BYTE_RD_LOW   = 3'd4;
  localparam logic [2:0] BYTE_RD_HIGH  = 3'd5;
  localparam logic [2:0] LAST_BIT      = 3'd7;

  typedef struct packed {
    logic [15:0] reset_low_ticks;
    logic [15:0] presence_timeout_ticks;
    logic [15:0] post_presence_ticks;
    logic [15:0] write_hold_ticks;
    logic [7:0]  read_sample_ticks;
    logic [15:0] read_slot_ticks;
    logic [19:0] conversion_wait_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               presence_fail;
    logic signed [15:0] raw_reading;
    logic [17:0]        centi_magnitude;
    logic               is_negative;
  } result_t;

  function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = CMD_SKIP_ROM;
      2'd1:    b = CMD_CONVERT;
      2'd2:    b = CMD_SKIP_ROM;
      default: b = CMD_READ_SCR;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/owtr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_cfg
// Timing register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module owtr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [owtr_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]   wr_data,
  output owtr_pkg::cfg_regs_t               regs
);

  owtr_pkg::cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.reset_low_ticks        <= owtr_pkg::RST_RESET_LOW;
      regs_r.presence_timeout_ticks <= owtr_pkg::RST_PRES_TMO;
      regs_r.post_presence_ticks    <= owtr_pkg::RST_POST_PRES;
      regs_r.write_hold_ticks       <= owtr_pkg::RST_WRITE_HOLD;
      regs_r.read_sample_ticks      <= owtr_pkg::RST_READ_SAMP;
      regs_r.read_slot_ticks        <= owtr_pkg::RST_READ_SLOT;
      regs_r.conversion_wait_ticks  <= owtr_pkg::RST_CONV_WAIT;
    end else if (wr_en) begin
      // Indexes past the register list are dropped.
      unique case (wr_index)
        owtr_pkg::CFG_RESET_LOW:  regs_r.reset_low_ticks        <= wr_data[15:0];
        owtr_pkg::CFG_PRES_TMO:   regs_r.presence_timeout_ticks <= wr_data[15:0];
        owtr_pkg::CFG_POST_PRES:  regs_r.post_presence_ticks    <= wr_data[15:0];
        owtr_pkg::CFG_WRITE_HOLD: regs_r.write_hold_ticks       <= wr_data[15:0];
        owtr_pkg::CFG_READ_SAMP:  regs_r.read_sample_ticks      <= wr_data[7:0];
        owtr_pkg::CFG_READ_SLOT:  regs_r.read_slot_ticks        <= wr_data[15:0];
        owtr_pkg::CFG_CONV_WAIT:  regs_r.conversion_wait_ticks  <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign regs = regs_r;

endmodule

// File: rtl/core/owtr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_seq
// Bus sequencer: phase register, tick counter, bit and byte counters, and
// the conversion of the read word. Advances one tick per accepted request.
// ----------------------------------------------------------------------------
module owtr_seq #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                line_in,
  input  logic                start_req,
  input  owtr_pkg::cfg_regs_t regs,
  output owtr_pkg::result_t   res
);

  localparam int LW = 33;
  localparam logic [LW-1:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  owtr_pkg::phase_t         phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]   tick_count_r, tick_count_nxt;
  logic [2:0]               bit_index_r, bit_index_nxt;
  logic [2:0]               byte_index_r, byte_index_nxt;
  logic [7:0]               shift_byte_r, shift_byte_nxt;
  logic [7:0]               low_byte_r, low_byte_nxt;
  logic [15:0]              reading_r, reading_nxt;
  logic [17:0]              centi_value_r, centi_value_nxt;
  logic                     negative_flag_r, negative_flag_nxt;
  logic                     fail_flag_r, fail_flag_nxt;
  logic                     done;

  // Shared tick timer.
  logic [19:0]              len_sel;
  logic [LW-1:0]            len_nz, len_clip;
  logic [COUNT_WIDTH-1:0]   el_cnt;
  logic                     el_done;

  // Next byte slot.
  logic [2:0]               sel_byte;
  owtr_pkg::phase_t         sb_phase;
  logic [7:0]               sb_shift;

  // Word conversion.
  logic [15:0]              word;
  logic [16:0]              mag;
  logic [21:0]              scaled;

  always_comb begin
    unique case (phase_r)
      owtr_pkg::PH_RST_LOW:   len_sel = {4'd0, regs.reset_low_ticks};
      owtr_pkg::PH_PRES_WAIT: len_sel = {4'd0, regs.presence_timeout_ticks};
      owtr_pkg::PH_POST:      len_sel = {4'd0, regs.post_presence_ticks};
      owtr_pkg::PH_WR_HOLD,
      owtr_pkg::PH_WR_GAP:    len_sel = {4'd0, regs.write_hold_ticks};
      owtr_pkg::PH_CONV:      len_sel = regs.conversion_wait_ticks;
      owtr_pkg::PH_RD_WAIT:   len_sel = {12'd0, regs.read_sample_ticks};
      owtr_pkg::PH_RD_SLOT:   len_sel = {4'd0, regs.read_slot_ticks};
      default:                len_sel = 20'd0;
    endcase
  end

  // A zero length counts as one tick; a length past the counter is clipped.
  assign len_nz   = (len_sel == 20'd0) ? 33'd1 : {13'd0, len_sel};
  assign len_clip = (len_nz > CNT_MAX) ? CNT_MAX : len_nz;
  assign el_cnt   = (&tick_count_r) ? tick_count_r : tick_count_r + 1'b1;
  assign el_done  = {{(LW-COUNT_WIDTH){1'b0}}, el_cnt} >= len_clip;

  always_comb begin
    if (phase_r == owtr_pkg::PH_WR_GAP) begin
      sel_byte = byte_index_r + 3'd1;
    end else if (phase_r == owtr_pkg::PH_RD_SLOT) begin
      sel_byte = owtr_pkg::BYTE_RD_HIGH;
    end else begin
      sel_byte = byte_index_r;
    end
    if (sel_byte < owtr_pkg::BYTE_CMDS) begin
      sb_phase = owtr_pkg::PH_WR_LOW;
      sb_shift = owtr_pkg::cmd_byte(sel_byte[1:0]);
    end else begin
      sb_phase = owtr_pkg::PH_RD_LOW;
      sb_shift = 8'd0;
    end
  end

  // Hundredths of a degree: round(6.25 * |word|) as (25 * |word| + 2) / 4.
  assign word   = {shift_byte_r, low_byte_r};
  assign mag    = word[15] ? (17'h10000 - {1'b0, word}) : {1'b0, word};
  assign scaled = ({5'd0, mag} << 4) + ({5'd0, mag} << 3) + {5'd0, mag} + 22'd2;

  always_comb begin
    phase_nxt         = phase_r;
    tick_count_nxt    = tick_count_r;
    bit_index_nxt     = bit_index_r;
    byte_index_nxt    = byte_index_r;
    shift_byte_nxt    = shift_byte_r;
    low_byte_nxt      = low_byte_r;
    reading_nxt       = reading_r;
    centi_value_nxt   = centi_value_r;
    negative_flag_nxt = negative_flag_r;
    fail_flag_nxt     = fail_flag_r;
    done              = 1'b0;

    unique case (phase_r)
      owtr_pkg::PH_IDLE: begin
        if (start_req) begin
          fail_flag_nxt  = 1'b0;
          byte_index_nxt = 3'd0;
          tick_count_nxt = '0;
          phase_nxt      = owtr_pkg::PH_RST_LOW;
        end
      end
      owtr_pkg::PH_RST_LOW: begin
        tick_count_nxt = el_done ? '0 : el_cnt;
        if (el_done) phase_nxt = owtr_pkg::PH_PRES_WAIT;
      end
      owtr_pkg::PH_PRES_WAIT: begin
        if (!line_in) begin
          tick_count_nxt = '0;
          if (regs.post_presence_ticks == 16'd0) begin
            bit_index_nxt  = 3'd0;
            shift_byte_nxt = sb_shift;
            phase_nxt      = sb_phase;
          end else begin
            phase_nxt = owtr_pkg::PH_POST;
          end
        end else begin
          tick_count_nxt = el_done ? '0 : el_cnt;
          if (el_done) begin
            fail_flag_nxt  = 1'b1;
            done           = 1'b1;
            byte_index_nxt = 3'd0;
            phase_nxt      = owtr_pkg::PH_IDLE;
          end
        end
      end
      owtr_pkg::PH_POST: begin
        tick_count_nxt = el_done ? '0 : el_cnt;
        if (el_done) begin
          bit_index_nxt  = 3'd0;
          shift_byte_nxt = sb_shift;
          phase_nxt      = sb_phase;
        end
      end
      owtr_pkg::PH_WR_LOW: begin
        tick_count_nxt = '0;
        phase_nxt      = owtr_pkg::PH_WR_HOLD;
      end
      owtr_pkg::PH_WR_HOLD: begin
        tick_count_nxt = el_done ? '0 : el_cnt;
        if (el_done) begin
          shift_byte_nxt = {1'b0, shift_byte_r[7:1]};
          if (bit_index_r >= owtr_pkg::LAST_BIT) begin
            bit_index_nxt = 3'd0;
            phase_nxt     = owtr_pkg::PH_WR_GAP;
          end else begin
            bit_index_nxt = bit_index_r + 3'd1;
            phase_nxt     = owtr_pkg::PH_WR_LOW;
          end
        end
      end
      owtr_pkg::PH_WR_GAP: begin
        tick_count_nxt = el_done ? '0 : el_cnt;
        if (el_done) begin
          byte_index_nxt = sel_byte;
          if (sel_byte == owtr_pkg::BYTE_CONV_END) begin
            if (regs.conversion_wait_ticks == 20'd0) begin
              phase_nxt = owtr_pkg::PH_RST_LOW;
            end else begin
              phase_nxt = owtr_pkg::PH_CONV;
            end
          end else begin
            bit_index_nxt  = 3'd0;
            shift_byte_nxt = sb_shift;
            phase_nxt      = sb_phase;
          end
        end
      end
      owtr_pkg::PH_CONV: begin
        tick_count_nxt = el_done ? '0 : el_cnt;
        if (el_done) phase_nxt = owtr_pkg::PH_RST_LOW;
      end
      owtr_pkg::PH_RD_LOW: begin
        tick_count_nxt = '0;
        phase_nxt      = owtr_pkg::PH_RD_WAIT;
      end
      owtr_pkg::PH_RD_WAIT: begin
        tick_count_nxt = el_done ? '0 : el_cnt;
        if (el_done) begin
          shift_byte_nxt = {line_in, shift_byte_r[7:1]};
          phase_nxt      = owtr_pkg::PH_RD_SLOT;
        end
      end
      owtr_pkg::PH_RD_SLOT: begin
        tick_count_nxt = el_done ? '0 : el_cnt;
        if (el_done) begin
          if (bit_index_r < owtr_pkg::LAST_BIT) begin
            bit_index_nxt = bit_index_r + 3'd1;
            phase_nxt     = owtr_pkg::PH_RD_LOW;
          end else if (byte_index_r == owtr_pkg::BYTE_RD_LOW) begin
            low_byte_nxt   = shift_byte_r;
            byte_index_nxt = owtr_pkg::BYTE_RD_HIGH;
            bit_index_nxt  = 3'd0;
            shift_byte_nxt = sb_shift;
            phase_nxt      = sb_phase;
          end else begin
            reading_nxt       = word;
            negative_flag_nxt = word[15];
            centi_value_nxt   = scaled[19:2];
            done              = 1'b1;
            bit_index_nxt     = 3'd0;
            byte_index_nxt    = 3'd0;
            phase_nxt         = owtr_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        tick_count_nxt = '0;
        bit_index_nxt  = 3'd0;
        byte_index_nxt = 3'd0;
        phase_nxt      = owtr_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res.drive_low = (phase_r == owtr_pkg::PH_RST_LOW) ||
                    (phase_r == owtr_pkg::PH_WR_LOW)  ||
                    (phase_r == owtr_pkg::PH_RD_LOW)  ||
                    ((phase_r == owtr_pkg::PH_WR_HOLD) && !shift_byte_r[0]);
    res.busy_res        = (phase_r != owtr_pkg::PH_IDLE);
    res.done_res        = done;
    res.presence_fail   = fail_flag_nxt;
    res.raw_reading     = reading_nxt;
    res.centi_magnitude = centi_value_nxt;
    res.is_negative     = negative_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= owtr_pkg::PH_IDLE;
      tick_count_r    <= '0;
      bit_index_r     <= 3'd0;
      byte_index_r    <= 3'd0;
      shift_byte_r    <= 8'd0;
      low_byte_r      <= 8'd0;
      reading_r       <= 16'd0;
      centi_value_r   <= 18'd0;
      negative_flag_r <= 1'b0;
      fail_flag_r     <= 1'b0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      tick_count_r    <= tick_count_nxt;
      bit_index_r     <= bit_index_nxt;
      byte_index_r    <= byte_index_nxt;
      shift_byte_r    <= shift_byte_nxt;
      low_byte_r      <= low_byte_nxt;
      reading_r       <= reading_nxt;
      centi_value_r   <= centi_value_nxt;
      negative_flag_r <= negative_flag_nxt;
      fail_flag_r     <= fail_flag_nxt;
    end
  end

endmodule

// File: rtl/core/one_wire_temperature_reader.sv
`timescale 1ns / 1ps
// Latency: the result of a tick request is valid in the cycle after it is accepted.
// Throughput: one tick request per cycle while in_ready is high; the sequencer state advances in one pass.
// The output register frees in_ready whenever it is empty or being taken.
// Reset (synchronous, rst_n low) returns the sequencer to idle, clears the
// reading and flags, and loads the timing registers with their defaults.
// ----------------------------------------------------------------------------
// one_wire_temperature_reader
// Single-wire bus master that measures and reads back one temperature word.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_line_in,
  input  logic                            in_start_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_drive_low,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic                            out_presence_fail,
  output logic signed [15:0]              out_raw_reading,
  output logic [17:0]                     out_centi_magnitude,
  output logic                            out_is_negative,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [owtr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owtr_pkg::CFG_DATA_W-1:0] cfg_data
);

  owtr_pkg::cfg_regs_t regs;
  owtr_pkg::result_t   res;
  owtr_pkg::result_t   out_item_r;
  logic                out_valid_r;
  logic                in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  owtr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  owtr_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .line_in   (in_line_in),
    .start_req (in_start_req),
    .regs      (regs),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_item_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive_low       = out_item_r.drive_low;
  assign out_busy_res        = out_item_r.busy_res;
  assign out_done_res        = out_item_r.done_res;
  assign out_presence_fail   = out_item_r.presence_fail;
  assign out_raw_reading     = out_item_r.raw_reading;
  assign out_centi_magnitude = out_item_r.centi_magnitude;
  assign out_is_negative     = out_item_r.is_negative;

endmodule

// File: rtl/core/owtr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_checker
// Port-level checks of the single-wire temperature reader.
// ----------------------------------------------------------------------------
`include "one_wire_temperature_reader_assert.svh"

module owtr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_drive_low,
  input logic               out_busy_res,
  input logic               out_done_res,
  input logic signed [15:0] out_raw_reading,
  input logic [17:0]        out_centi_magnitude
);

  // A stalled result keeps its contents.
  `OWTR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_raw_reading) && $stable(out_centi_magnitude) && $stable(out_done_res), "stalled result changed")

  // Every accepted request yields a result in the next cycle.
  `OWTR_ASSERT_NEXT(a_req_result, clk, rst_n, in_valid && in_ready, out_valid, "accepted request produced no result")

  // The end of a sequence is reported on a busy tick.
  `OWTR_ASSERT(a_done_busy, clk, rst_n, !(out_valid && out_done_res) || out_busy_res, "done reported while idle")

  // The bus is only pulled low inside a sequence.
  `OWTR_ASSERT(a_drive_busy, clk, rst_n, !(out_valid && out_drive_low) || out_busy_res, "bus driven while idle")

endmodule

bind one_wire_temperature_reader owtr_checker u_owtr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_drive_low       (out_drive_low),
  .out_busy_res        (out_busy_res),
  .out_done_res        (out_done_res),
  .out_raw_reading     (out_raw_reading),
  .out_centi_magnitude (out_centi_magnitude)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the single-wire temperature reader one bus tick at a time. A device
// model answers the presence and read slots with chosen temperature words.
// A cycle-exact prediction of the sequencer is compared with every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int                             STUCK_LIMIT     = 4000;
  localparam int                             HOLD_OFF_CYCLES = 300;
  localparam int                             RANDOM_TICKS    = 300;
  localparam logic [19:0]                    TICK_MAX        = 20'hfffff;
  localparam logic [owtr_pkg::CFG_IDX_W-1:0] CFG_UNUSED      = 3'd7;

  logic                            clk          = 1'b0;
  logic                            rst_n        = 1'b0;
  logic                            in_valid     = 1'b0;
  logic                            in_line_in   = 1'b1;
  logic                            in_start_req = 1'b0;
  logic                            out_ready    = 1'b0;
  logic                            cfg_valid    = 1'b0;
  logic [owtr_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [owtr_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
  logic                            cfg_ready;
  logic                            in_ready;
  logic                            out_valid;
  logic                            out_drive_low;
  logic                            out_busy_res;
  logic                            out_done_res;
  logic                            out_presence_fail;
  logic signed [15:0]              out_raw_reading;
  logic [17:0]                     out_centi_magnitude;
  logic                            out_is_negative;

  one_wire_temperature_reader dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_line_in          (in_line_in),
    .in_start_req        (in_start_req),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_drive_low       (out_drive_low),
    .out_busy_res        (out_busy_res),
    .out_done_res        (out_done_res),
    .out_presence_fail   (out_presence_fail),
    .out_raw_reading     (out_raw_reading),
    .out_centi_magnitude (out_centi_magnitude),
    .out_is_negative     (out_is_negative),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #4 clk = ~clk;

  // Predicted sequencer state.
  owtr_pkg::cfg_regs_t timing;
  owtr_pkg::phase_t    bus_phase;
  logic [19:0]         slot_ticks;
  logic [2:0]          bit_pos;
  logic [2:0]          byte_pos;
  logic [7:0]          shreg;
  logic [7:0]          low_byte_q;
  logic [15:0]         word_q;
  logic [17:0]         centi_q;
  logic                neg_q;
  logic                fail_q;

  // Bus device behavior.
  logic [15:0] dev_word;
  logic        dev_present;

  owtr_pkg::result_t pending_results[$];
  int      error_count   = 0;
  int      result_count  = 0;
  int      stuck_cycles  = 0;
  bit      steady        = 1'b0;
  bit      sink_hold_req = 1'b0;
  bit      cfg_open      = 1'b0;

  function automatic bit slot_elapsed(input logic [19:0] len_in);
    logic [19:0] len;
    len = (len_in == '0) ? 20'd1 : len_in;
    if (slot_ticks != TICK_MAX) slot_ticks = slot_ticks + 20'd1;
    if (slot_ticks >= len) begin
      slot_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void begin_reset_pulse();
    slot_ticks = '0;
    bus_phase  = owtr_pkg::PH_RST_LOW;
  endfunction

  function automatic void begin_byte();
    slot_ticks = '0;
    bit_pos    = '0;
    if (byte_pos < owtr_pkg::BYTE_CMDS) begin
      case (byte_pos)
        3'd1:    shreg = owtr_pkg::CMD_CONVERT;
        3'd3:    shreg = owtr_pkg::CMD_READ_SCR;
        default: shreg = owtr_pkg::CMD_SKIP_ROM;
      endcase
      bus_phase = owtr_pkg::PH_WR_LOW;
    end else begin
      shreg     = '0;
      bus_phase = owtr_pkg::PH_RD_LOW;
    end
  endfunction

  function automatic owtr_pkg::result_t bus_master_tick(input logic line, input logic start);
    owtr_pkg::result_t r;
    logic              finished;
    int                mag;
    r = '0;
    finished = 1'b0;
    r.drive_low = (bus_phase == owtr_pkg::PH_RST_LOW) ||
                  (bus_phase == owtr_pkg::PH_WR_LOW) ||
                  (bus_phase == owtr_pkg::PH_RD_LOW) ||
                  (bus_phase == owtr_pkg::PH_WR_HOLD && !shreg[0]);
    r.busy_res  = (bus_phase != owtr_pkg::PH_IDLE);
    case (bus_phase)
      owtr_pkg::PH_IDLE: begin
        if (start) begin
          fail_q   = 1'b0;
          byte_pos = '0;
          begin_reset_pulse();
        end
      end
      owtr_pkg::PH_RST_LOW: begin
        if (slot_elapsed(timing.reset_low_ticks)) bus_phase = owtr_pkg::PH_PRES_WAIT;
      end
      owtr_pkg::PH_PRES_WAIT: begin
        if (!line) begin
          slot_ticks = '0;
          if (timing.post_presence_ticks == '0) begin_byte();
          else bus_phase = owtr_pkg::PH_POST;
        end else if (slot_elapsed(timing.presence_timeout_ticks)) begin
          fail_q    = 1'b1;
          finished  = 1'b1;
          byte_pos  = '0;
          bus_phase = owtr_pkg::PH_IDLE;
        end
      end
      owtr_pkg::PH_POST: begin
        if (slot_elapsed(timing.post_presence_ticks)) begin_byte();
      end
      owtr_pkg::PH_WR_LOW: begin
        slot_ticks = '0;
        bus_phase  = owtr_pkg::PH_WR_HOLD;
      end
      owtr_pkg::PH_WR_HOLD: begin
        if (slot_elapsed(timing.write_hold_ticks)) begin
          shreg = shreg >> 1;
          if (bit_pos >= owtr_pkg::LAST_BIT) begin
            bit_pos   = '0;
            bus_phase = owtr_pkg::PH_WR_GAP;
          end else begin
            bit_pos   = bit_pos + 3'd1;
            bus_phase = owtr_pkg::PH_WR_LOW;
          end
        end
      end
      owtr_pkg::PH_WR_GAP: begin
        if (slot_elapsed(timing.write_hold_ticks)) begin
          byte_pos = byte_pos + 3'd1;
          if (byte_pos == owtr_pkg::BYTE_CONV_END) begin
            slot_ticks = '0;
            if (timing.conversion_wait_ticks == '0) begin_reset_pulse();
            else bus_phase = owtr_pkg::PH_CONV;
          end else begin
            begin_byte();
          end
        end
      end
      owtr_pkg::PH_CONV: begin
        if (slot_elapsed(timing.conversion_wait_ticks)) begin_reset_pulse();
      end
      owtr_pkg::PH_RD_LOW: begin
        slot_ticks = '0;
        bus_phase  = owtr_pkg::PH_RD_WAIT;
      end
      owtr_pkg::PH_RD_WAIT: begin
        if (slot_elapsed(timing.read_sample_ticks)) begin
          shreg     = {line, shreg[7:1]};
          bus_phase = owtr_pkg::PH_RD_SLOT;
        end
      end
      owtr_pkg::PH_RD_SLOT: begin
        if (slot_elapsed(timing.read_slot_ticks)) begin
          if (bit_pos < owtr_pkg::LAST_BIT) begin
            bit_pos   = bit_pos + 3'd1;
            bus_phase = owtr_pkg::PH_RD_LOW;
          end else if (byte_pos == owtr_pkg::BYTE_RD_LOW) begin
            low_byte_q = shreg;
            byte_pos   = owtr_pkg::BYTE_RD_HIGH;
            begin_byte();
          end else begin
            word_q    = {shreg, low_byte_q};
            neg_q     = word_q[15];
            mag       = neg_q ? 65536 - int'(word_q) : int'(word_q);
            centi_q   = 18'((25 * mag + 2) >> 2);
            finished  = 1'b1;
            bit_pos   = '0;
            byte_pos  = '0;
            bus_phase = owtr_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        slot_ticks = '0;
        bit_pos    = '0;
        byte_pos   = '0;
        bus_phase  = owtr_pkg::PH_IDLE;
      end
    endcase
    r.done_res        = finished;
    r.presence_fail   = fail_q;
    r.raw_reading     = word_q;
    r.centi_magnitude = centi_q;
    r.is_negative     = neg_q;
    return r;
  endfunction

  // Level the device puts on the bus in the tick about to be sent. The line
  // is noise except while a presence pulse or a read sample is due.
  function automatic logic device_line();
    logic [19:0] sample_len;
    logic [3:0]  pos;
    if (bus_phase == owtr_pkg::PH_PRES_WAIT) begin
      return dev_present ? ($urandom_range(0, 2) != 0) : 1'b1;
    end else if (bus_phase == owtr_pkg::PH_RD_WAIT) begin
      sample_len = (timing.read_sample_ticks == '0) ? 20'd1 : 20'(timing.read_sample_ticks);
      pos = {byte_pos == owtr_pkg::BYTE_RD_HIGH, bit_pos};
      if (slot_ticks + 20'd1 >= sample_len) return dev_word[pos];
    end
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic close_cfg();
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
  endtask

  task automatic send_tick(input logic line, input logic start);
    close_cfg();
    if (!steady && $urandom_range(0, 15) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_line_in   <= line;
    in_start_req <= start;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(bus_master_tick(line, start));
  endtask

  // A start request is made with the given odds while idle; while busy the
  // request toggles at random and must be ignored.
  task automatic send_device_tick(input int start_pct);
    logic line;
    logic start;
    line = device_line();
    if (bus_phase == owtr_pkg::PH_IDLE) start = ($urandom_range(0, 99) < start_pct);
    else start = 1'($urandom_range(0, 1));
    send_tick(line, start);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [owtr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [owtr_pkg::CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_open = 1'b1;
    case (idx)
      owtr_pkg::CFG_RESET_LOW:  timing.reset_low_ticks        = data[15:0];
      owtr_pkg::CFG_PRES_TMO:   timing.presence_timeout_ticks = data[15:0];
      owtr_pkg::CFG_POST_PRES:  timing.post_presence_ticks    = data[15:0];
      owtr_pkg::CFG_WRITE_HOLD: timing.write_hold_ticks       = data[15:0];
      owtr_pkg::CFG_READ_SAMP:  timing.read_sample_ticks      = data[7:0];
      owtr_pkg::CFG_READ_SLOT:  timing.read_slot_ticks        = data[15:0];
      owtr_pkg::CFG_CONV_WAIT:  timing.conversion_wait_ticks  = data;
      default: ;
    endcase
  endtask

  task automatic program_timing(input int rst_low, pres_tmo, post, hold, samp, slot,
                                conv);
    write_reg(owtr_pkg::CFG_RESET_LOW, 20'(rst_low));
    write_reg(owtr_pkg::CFG_PRES_TMO, 20'(pres_tmo));
    write_reg(owtr_pkg::CFG_POST_PRES, 20'(post));
    write_reg(owtr_pkg::CFG_WRITE_HOLD, 20'(hold));
    write_reg(owtr_pkg::CFG_READ_SAMP, 20'(samp));
    write_reg(owtr_pkg::CFG_READ_SLOT, 20'(slot));
    write_reg(owtr_pkg::CFG_CONV_WAIT, 20'(conv));
  endtask

  // Runs one measurement (or the rest of one) until the sequencer is idle.
  task automatic measure(input logic [15:0] word, input logic present);
    dev_word    = word;
    dev_present = present;
    do send_device_tick(100); while (bus_phase != owtr_pkg::PH_IDLE);
  endtask

  task automatic run_until(input owtr_pkg::phase_t target, input int extra);
    while (bus_phase != target) send_device_tick(100);
    repeat (extra) send_device_tick(0);
  endtask

  task automatic test_idle_after_reset();
    repeat (20) send_tick(1'($urandom_range(0, 1)), 1'b0);
    write_reg(CFG_UNUSED, 20'($urandom_range(0, 1048575)));
    repeat (10) send_tick(1'($urandom_range(0, 1)), 1'b0);
  endtask

  // The reset pulse runs for a while with the power-on timing before the
  // timing is shortened so the measurement can finish.
  task automatic test_default_timing();
    dev_word    = 16'h0550;
    dev_present = 1'b1;
    run_until(owtr_pkg::PH_RST_LOW, 120);
    program_timing(1, 4, 0, 1, 1, 1, 0);
    measure(16'h0550, 1'b1);
  endtask

  task automatic test_readings();
    logic [15:0] words[4];
    words = '{16'h8000, 16'hffff, 16'h0002, 16'h7fff};
    program_timing(1, 4, 0, 1, 1, 1, 0);
    foreach (words[i]) measure(words[i], 1'b1);
  endtask

  task automatic test_zero_lengths();
    program_timing(0, 0, 0, 0, 0, 0, 0);
    measure(16'($urandom_range(0, 65535)), 1'b1);
    program_timing(3, 6, 2, 2, 3, 2, 4);
    measure(16'hc001, 1'b1);
  endtask

  task automatic test_missing_presence();
    program_timing(1, 1, 0, 1, 1, 1, 0);
    measure(16'h1234, 1'b0);
    measure(16'hfc90, 1'b1);
    program_timing(2, 7, 1, 1, 1, 1, 0);
    // The earlier reading must survive an aborted sequence.
    measure(16'h4321, 1'b0);
  endtask

  // Waits too long to run in full are entered, left running for a while
  // and then shortened so the sequence can finish.
  task automatic test_long_waits();
    program_timing(1, 100, 0, 65535, 1, 65535, 1048575);
    dev_word    = 16'hc3a5;
    dev_present = 1'b1;
    run_until(owtr_pkg::PH_WR_HOLD, 30);
    write_reg(owtr_pkg::CFG_WRITE_HOLD, 20'd2);
    run_until(owtr_pkg::PH_CONV, 30);
    write_reg(owtr_pkg::CFG_CONV_WAIT, 20'd3);
    run_until(owtr_pkg::PH_RD_SLOT, 30);
    write_reg(owtr_pkg::CFG_READ_SLOT, 20'd2);
    measure(dev_word, 1'b1);
  endtask

  task automatic test_backpressure();
    program_timing(1, 3, 1, 1, 1, 1, 1);
    dev_word    = 16'h0a5f;
    dev_present = 1'b1;
    sink_hold_req = 1'b1;
    repeat (80) send_device_tick(50);
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    int seg_len;
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      program_timing($urandom_range(0, 4), $urandom_range(1, 10), $urandom_range(0, 3),
                     $urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(0, 2),
                     $urandom_range(0, 5));
      seg_len = $urandom_range(100, 150);
      repeat (seg_len) begin
        if (bus_phase == owtr_pkg::PH_IDLE) begin
          dev_present = ($urandom_range(0, 7) != 0);
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
              0:       dev_word = 16'h0000;
              1:       dev_word = 16'h7fff;
              2:       dev_word = 16'h8000;
              3:       dev_word = 16'hffff;
              4:       dev_word = 16'h0001;
              default: dev_word = 16'hfff8;
            endcase
          end else begin
            dev_word = 16'($urandom_range(0, 65535));
          end
        end
        if (sent >= RANDOM_TICKS - 150) steady = 1'b1;
        send_device_tick(30);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    timing.reset_low_ticks        = owtr_pkg::RST_RESET_LOW;
    timing.presence_timeout_ticks = owtr_pkg::RST_PRES_TMO;
    timing.post_presence_ticks    = owtr_pkg::RST_POST_PRES;
    timing.write_hold_ticks       = owtr_pkg::RST_WRITE_HOLD;
    timing.read_sample_ticks      = owtr_pkg::RST_READ_SAMP;
    timing.read_slot_ticks        = owtr_pkg::RST_READ_SLOT;
    timing.conversion_wait_ticks  = owtr_pkg::RST_CONV_WAIT;
    bus_phase  = owtr_pkg::PH_IDLE;
    slot_ticks = '0;
    bit_pos    = '0;
    byte_pos   = '0;
    shreg      = '0;
    low_byte_q = '0;
    word_q     = '0;
    centi_q    = '0;
    neg_q      = 1'b0;
    fail_q     = 1'b0;
    dev_word    = '0;
    dev_present = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_after_reset();
    test_default_timing();
    test_readings();
    test_zero_lengths();
    test_missing_presence();
    test_long_waits();
    test_backpressure();
    test_random();
    wait_drained();
    close_cfg();
    repeat (4) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : sink
    forever begin
      if (sink_hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 15) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    owtr_pkg::result_t want;
    owtr_pkg::result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.drive_low       = out_drive_low;
      got.busy_res        = out_busy_res;
      got.done_res        = out_done_res;
      got.presence_fail   = out_presence_fail;
      got.raw_reading     = out_raw_reading;
      got.centi_magnitude = out_centi_magnitude;
      got.is_negative     = out_is_negative;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("tb: unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (want.drive_low !== got.drive_low || want.busy_res !== got.busy_res ||
            want.done_res !== got.done_res || want.presence_fail !== got.presence_fail ||
            want.raw_reading !== got.raw_reading ||
            want.centi_magnitude !== got.centi_magnitude ||
            want.is_negative !== got.is_negative) begin
          error_count++;
          if (error_count <= 10) begin
            $display("tb: #%0d exp drive=%b busy=%b done=%b fail=%b raw=%h centi=%0d neg=%b",
                     result_count, want.drive_low, want.busy_res, want.done_res,
                     want.presence_fail, want.raw_reading, want.centi_magnitude,
                     want.is_negative);
            $display("tb: #%0d got drive=%b busy=%b done=%b fail=%b raw=%h centi=%0d neg=%b",
                     result_count, got.drive_low, got.busy_res, got.done_res,
                     got.presence_fail, got.raw_reading, got.centi_magnitude,
                     got.is_negative);
          end
        end
      end
      result_count++;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/owtr_pkg.sv
rtl/core/owtr_cfg.sv
rtl/core/owtr_seq.sv
rtl/core/one_wire_temperature_reader.sv
rtl/core/owtr_checker.sv
dv/tb.sv
